/* hdl/atsa_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and tables for the tilt to servo angle block
// no dependencies; used by the interfaces and every module

package atsa_pkg;

  // sample and cordic sizing
  localparam int CORDIC_STAGES = 16;
  localparam int ACCEL_WIDTH   = 16;
  localparam int TABLE_LEN     = 24;
  localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // vector words: 16 bits of pre-scale plus headroom for cordic gain
  localparam int SCALE_SH = 16;
  localparam int VEC_W    = ACCEL_WIDTH + SCALE_SH + 3;

  // angles in degrees with 8 fractional bits
  localparam int ANG_W    = 18;
  localparam int ANG_FRAC = 8;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t HALF_TURN = ang_t'(180 * 256);
  localparam ang_t FRAC_ROUND = ang_t'((1 << ANG_FRAC) - 1);

  // atan(2^-i) in degrees, q8
  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    ang_t'(11520), ang_t'(6801), ang_t'(3593), ang_t'(1824),
    ang_t'(916),   ang_t'(458),  ang_t'(229),  ang_t'(115),
    ang_t'(57),    ang_t'(29),   ang_t'(14),   ang_t'(7),
    ang_t'(4),     ang_t'(2),    ang_t'(1),    ang_t'(0),
    ang_t'(0),     ang_t'(0),    ang_t'(0),    ang_t'(0),
    ang_t'(0),     ang_t'(0),    ang_t'(0),    ang_t'(0)
  };

  // whole degree tilt, -180..180
  localparam int TILT_W   = 9;
  localparam int TILT_MAX = 180;
  localparam int TILT_BIAS = 90;
  localparam int SHIFTED_W = TILT_W + 1;

  // servo mapping: (t + 90) * limit, then divide by 180
  localparam int SERVO_W   = 8;
  localparam int MAP_W     = 18;
  localparam int MAG_W     = 17;
  localparam int DIV_SHIFT = 25;
  localparam int DIV_DEN   = 180;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + DIV_DEN - 1) / DIV_DEN;
  localparam int DIV_MUL_W = 18;
  localparam int DIV_PROD_W = MAG_W + DIV_MUL_W;
  localparam int QUO_W     = 9;
  localparam int SUM_W     = 11;
  typedef logic signed [MAP_W-1:0] map_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // pipeline depth: preprocess, cordic stages, three mapping stages
  localparam int MAP_LAT  = 3;
  localparam int PIPE_LAT = 1 + RUN_STAGES + MAP_LAT;

  // configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_OFFSET,
    CFG_ROLL_OFFSET,
    CFG_SPAN_LIMIT
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] PITCH_OFFSET_RST = 8'd42;
  localparam logic [CFG_W-1:0] ROLL_OFFSET_RST  = 8'd12;
  localparam logic [CFG_W-1:0] SPAN_LIMIT_RST   = 8'd130;

  // what one cordic lane hands to the mapping stage
  typedef struct packed {
    logic zero;
    ang_t ang;
  } lane_res_t;

endpackage

/* hdl/atsa_in_if.sv */
`timescale 1ns / 1ps
// input channel: one accelerometer sample word
// depends on atsa_pkg

interface atsa_in_if;
  logic valid;
  logic ready;
  logic signed [atsa_pkg::ACCEL_WIDTH-1:0] accel_x;
  logic signed [atsa_pkg::ACCEL_WIDTH-1:0] accel_y;
  logic signed [atsa_pkg::ACCEL_WIDTH-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

/* hdl/atsa_out_if.sv */
`timescale 1ns / 1ps
// result channel: one word with both servo angles
// depends on atsa_pkg

interface atsa_out_if;
  logic valid;
  logic ready;
  logic [atsa_pkg::SERVO_W-1:0] first_servo_angle;
  logic [atsa_pkg::SERVO_W-1:0] second_servo_angle;

  modport source (output valid, output first_servo_angle, output second_servo_angle,
                  input ready);
  modport sink (input valid, input first_servo_angle, input second_servo_angle,
                output ready);
endinterface

/* hdl/atsa_cordic_lane.sv */
`timescale 1ns / 1ps
// one pipelined cordic lane computing atan2(num, den) in q8 degrees
// depends on atsa_pkg

module atsa_cordic_lane (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [atsa_pkg::ACCEL_WIDTH-1:0]  num,
  input  logic signed [atsa_pkg::ACCEL_WIDTH-1:0]  den,
  output atsa_pkg::lane_res_t                      res
);

  typedef logic signed [atsa_pkg::VEC_W-1:0] vec_t;

  vec_t              x_r    [atsa_pkg::RUN_STAGES+1];
  vec_t              y_r    [atsa_pkg::RUN_STAGES+1];
  atsa_pkg::ang_t    z_r    [atsa_pkg::RUN_STAGES+1];
  logic              zero_r [atsa_pkg::RUN_STAGES+1];
  vec_t              x_nxt  [atsa_pkg::RUN_STAGES+1];
  vec_t              y_nxt  [atsa_pkg::RUN_STAGES+1];
  atsa_pkg::ang_t    z_nxt  [atsa_pkg::RUN_STAGES+1];
  logic              zero_nxt [atsa_pkg::RUN_STAGES+1];

  vec_t x_scaled;
  vec_t y_scaled;

  // scale up and fold the left half plane into the right
  assign x_scaled = vec_t'(den) <<< atsa_pkg::SCALE_SH;
  assign y_scaled = vec_t'(num) <<< atsa_pkg::SCALE_SH;

  always_comb begin
    zero_nxt[0] = (num == '0) && (den == '0);
    if (den < 0) begin
      x_nxt[0] = -x_scaled;
      y_nxt[0] = -y_scaled;
      z_nxt[0] = (num >= 0) ? atsa_pkg::HALF_TURN : -atsa_pkg::HALF_TURN;
    end else begin
      x_nxt[0] = x_scaled;
      y_nxt[0] = y_scaled;
      z_nxt[0] = '0;
    end

    // vectoring iterations, one per pipeline stage
    for (int i = 0; i < atsa_pkg::RUN_STAGES; i++) begin
      zero_nxt[i+1] = zero_r[i];
      if (!y_r[i][atsa_pkg::VEC_W-1]) begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + atsa_pkg::ATAN_TAB[i];
      end else begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - atsa_pkg::ATAN_TAB[i];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign res.zero = zero_r[atsa_pkg::RUN_STAGES];
  assign res.ang  = z_r[atsa_pkg::RUN_STAGES];

endmodule

/* hdl/atsa_servo_map.sv */
`timescale 1ns / 1ps
// merge stage: whole-degree tilt, linear servo mapping and clamping
// depends on atsa_pkg; fed by atsa_cordic_lane

module atsa_servo_map (
  input  logic                            clk,
  input  logic                            en,
  input  atsa_pkg::lane_res_t             res,
  input  logic [atsa_pkg::CFG_W-1:0]      offset,
  input  logic [atsa_pkg::CFG_W-1:0]      limit,
  output logic [atsa_pkg::SERVO_W-1:0]    angle
);

  atsa_pkg::ang_t                         ang_biased;
  atsa_pkg::ang_t                         ang_whole;
  logic signed [atsa_pkg::TILT_W-1:0]     tilt;
  logic signed [atsa_pkg::SHIFTED_W-1:0]  tilt_shifted;
  atsa_pkg::map_t                         prod_nxt;
  atsa_pkg::map_t                         prod_r;
  atsa_pkg::map_t                         prod_mag;
  logic [atsa_pkg::DIV_PROD_W-1:0]        quot_nxt;
  logic [atsa_pkg::DIV_PROD_W-1:0]        quot_r;
  logic                                   neg_r;
  logic [atsa_pkg::QUO_W-1:0]             quot;
  atsa_pkg::sum_t                         mapped;
  atsa_pkg::sum_t                         off_ext;
  atsa_pkg::sum_t                         lim_ext;
  logic [atsa_pkg::SERVO_W-1:0]           angle_nxt;
  logic [atsa_pkg::SERVO_W-1:0]           angle_r;

  // truncate toward zero to whole degrees, clamp, scale by the span
  always_comb begin
    ang_biased = res.ang + (res.ang[atsa_pkg::ANG_W-1] ? atsa_pkg::FRAC_ROUND : '0);
    ang_whole  = ang_biased >>> atsa_pkg::ANG_FRAC;
    if (res.zero) begin
      tilt = '0;
    end else if (ang_whole > atsa_pkg::ang_t'(atsa_pkg::TILT_MAX)) begin
      tilt = atsa_pkg::TILT_W'(atsa_pkg::TILT_MAX);
    end else if (ang_whole < atsa_pkg::ang_t'(-atsa_pkg::TILT_MAX)) begin
      tilt = atsa_pkg::TILT_W'(-atsa_pkg::TILT_MAX);
    end else begin
      tilt = ang_whole[atsa_pkg::TILT_W-1:0];
    end
    tilt_shifted = atsa_pkg::SHIFTED_W'(tilt)
                   + atsa_pkg::SHIFTED_W'(atsa_pkg::TILT_BIAS);
    prod_nxt = atsa_pkg::map_t'(tilt_shifted) * atsa_pkg::map_t'({1'b0, limit});
  end

  // divide by 180 through a reciprocal multiply on the magnitude
  always_comb begin
    prod_mag = prod_r[atsa_pkg::MAP_W-1] ? -prod_r : prod_r;
    quot_nxt = atsa_pkg::DIV_PROD_W'(prod_mag[atsa_pkg::MAG_W-1:0])
               * atsa_pkg::DIV_PROD_W'(atsa_pkg::DIV_MUL);
  end

  // restore sign, add offset, clamp to offset..limit
  always_comb begin
    quot    = quot_r[atsa_pkg::DIV_SHIFT +: atsa_pkg::QUO_W];
    off_ext = atsa_pkg::sum_t'({1'b0, offset});
    lim_ext = atsa_pkg::sum_t'({1'b0, limit});
    mapped  = (neg_r ? -atsa_pkg::sum_t'({1'b0, quot}) : atsa_pkg::sum_t'({1'b0, quot}))
              + off_ext;
    if (offset > limit) begin
      angle_nxt = offset;
    end else if (mapped < off_ext) begin
      angle_nxt = offset;
    end else if (mapped > lim_ext) begin
      angle_nxt = limit;
    end else begin
      angle_nxt = mapped[atsa_pkg::SERVO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      quot_r  <= quot_nxt;
      neg_r   <= prod_r[atsa_pkg::MAP_W-1];
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

/* hdl/accel_tilt_to_servo_angles.sv */
`timescale 1ns / 1ps
// top level: two cordic lanes (x over z, y over z) and their servo mapping stages
// depends on atsa_pkg, atsa_in_if, atsa_out_if, atsa_cordic_lane, atsa_servo_map

// Takes one accelerometer word per clock while no result is held at the output
// and returns one word with both servo angles after 1 preprocessing stage, 16
// cordic stages and 3 mapping stages. The two atan2 computations run in
// separate fully pipelined lanes, so a new word is taken every cycle as long as
// the output is being drained; while a result is held at the output, the whole
// pipeline holds and in_ch.ready is low. Configuration registers are read live
// by the mapping stages, so write them only while no word is in flight.

module accel_tilt_to_servo_angles (
  input  logic                              clk,
  input  logic                              rst_n,
  atsa_in_if.sink                           in_ch,
  atsa_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [atsa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [atsa_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [atsa_pkg::CFG_W-1:0]     pitch_off_r;
  logic [atsa_pkg::CFG_W-1:0]     roll_off_r;
  logic [atsa_pkg::CFG_W-1:0]     span_lim_r;
  logic [atsa_pkg::PIPE_LAT-1:0]  vld_r;
  logic [atsa_pkg::PIPE_LAT-1:0]  vld_nxt;
  logic                           en;
  atsa_pkg::lane_res_t            pitch_res;
  atsa_pkg::lane_res_t            roll_res;

  // pipeline advances whenever the output slot is free or being taken
  assign en           = !vld_r[atsa_pkg::PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[atsa_pkg::PIPE_LAT-1];
  assign vld_nxt      = {vld_r[atsa_pkg::PIPE_LAT-2:0], in_ch.valid};

  // word valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_off_r <= atsa_pkg::PITCH_OFFSET_RST;
      roll_off_r  <= atsa_pkg::ROLL_OFFSET_RST;
      span_lim_r  <= atsa_pkg::SPAN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        atsa_pkg::CFG_PITCH_OFFSET: begin
          pitch_off_r <= cfg_wdata;
        end
        atsa_pkg::CFG_ROLL_OFFSET: begin
          roll_off_r <= cfg_wdata;
        end
        atsa_pkg::CFG_SPAN_LIMIT: begin
          span_lim_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // cordic lanes
  atsa_cordic_lane u_pitch_lane (
    .clk (clk),
    .en  (en),
    .num (in_ch.accel_x),
    .den (in_ch.accel_z),
    .res (pitch_res)
  );

  atsa_cordic_lane u_roll_lane (
    .clk (clk),
    .en  (en),
    .num (in_ch.accel_y),
    .den (in_ch.accel_z),
    .res (roll_res)
  );

  // mapping stages, merged into one output word
  atsa_servo_map u_pitch_map (
    .clk    (clk),
    .en     (en),
    .res    (pitch_res),
    .offset (pitch_off_r),
    .limit  (span_lim_r),
    .angle  (out_ch.first_servo_angle)
  );

  atsa_servo_map u_roll_map (
    .clk    (clk),
    .en     (en),
    .res    (roll_res),
    .offset (roll_off_r),
    .limit  (span_lim_r),
    .angle  (out_ch.second_servo_angle)
  );

`ifndef SYNTHESIS
  // no result may be presented right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // a held result freezes the pipeline, so nothing new may enter
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output is held");

  // every accepted word enters the valid chain
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted word lost from valid chain");
`endif

endmodule
